// ----- rtl/core/dnle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] DOT_CHAR  = 8'h2E;
    localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_LEN,
        ST_DATA,
        ST_ZERO
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              trunc;
    } emit_t;

endpackage

// ----- rtl/core/dnle_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dnle_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 62,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/dnle_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnle_ctrl
// Label sequencer: buffers label characters into the store and replays a
// closed label as a length byte and its characters, ending a name with 0x00.
// ----------------------------------------------------------------------------
module dnle_ctrl
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = 62,
    parameter int CNT_W     = $clog2(LABEL_MAX + 1),
    parameter int ADDR_W    = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] name_byte,
    input  logic              name_end,
    input  logic              emit_ready,
    output emit_t             emit,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [BYTE_W-1:0] rd_data
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(LABEL_MAX);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] length_reg, length_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             ovf_reg, ovf_next;
    logic             end_reg, end_next;
    logic             accept;
    logic             last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_COLLECT;
            length_reg <= '0;
            idx_reg    <= '0;
            ovf_reg    <= 1'b0;
            end_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            idx_reg    <= idx_next;
            ovf_reg    <= ovf_next;
            end_reg    <= end_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        length_next = length_reg;
        idx_next    = idx_reg;
        ovf_next    = ovf_reg;
        end_next    = end_reg;
        in_stall    = (state_reg != ST_COLLECT);
        accept      = in_valid && !in_stall;
        last_byte   = (idx_reg == length_reg);
        emit        = '0;
        wr_en       = 1'b0;
        wr_addr     = length_reg[ADDR_W-1:0];
        wr_data     = name_byte;
        rd_en       = 1'b0;
        rd_addr     = idx_reg[ADDR_W-1:0];

        case (state_reg)
            ST_COLLECT:
            begin
                if (accept)
                begin
                    if (name_end)
                    begin
                        end_next   = 1'b1;
                        state_next = (length_reg != '0) ? ST_LEN : ST_ZERO;
                    end
                    else if (name_byte == DOT_CHAR)
                    begin
                        if (length_reg != '0)
                        begin
                            state_next = ST_LEN;
                        end
                        else
                        begin
                            ovf_next = 1'b0;
                        end
                    end
                    else if (length_reg < MAX_CNT)
                    begin
                        wr_en       = 1'b1;
                        length_next = CNT_W'(length_reg + 1'b1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                emit.valid = 1'b1;
                emit.data  = BYTE_W'(length_reg);
                emit.trunc = ovf_reg;
                if (emit_ready)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = CNT_W'(1);
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                emit.valid = 1'b1;
                emit.data  = rd_data;
                emit.trunc = ovf_reg;
                emit.last  = last_byte && !end_reg;
                if (emit_ready)
                begin
                    if (last_byte)
                    begin
                        length_next = '0;
                        ovf_next    = 1'b0;
                        state_next  = end_reg ? ST_ZERO : ST_COLLECT;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = CNT_W'(idx_reg + 1'b1);
                    end
                end
            end
            ST_ZERO:
            begin
                emit.valid = 1'b1;
                emit.data  = ZERO_BYTE;
                emit.last  = 1'b1;
                if (emit_ready)
                begin
                    end_next    = 1'b0;
                    length_next = '0;
                    ovf_next    = 1'b0;
                    state_next  = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= MAX_CNT)
        else $error("label length above maximum");

    a_len_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN || state_reg == ST_DATA) |-> length_reg != '0)
        else $error("empty label replayed");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DATA) |-> (idx_reg != '0 && idx_reg <= length_reg))
        else $error("replay index out of range");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> length_reg == MAX_CNT)
        else $error("truncation flag without full label");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ZERO && emit_ready) |=>
            (state_reg == ST_COLLECT && length_reg == '0 && !end_reg))
        else $error("terminator did not clear state");

endmodule

// ----- rtl/core/dns_name_label_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Converts a dotted domain name, one character per transaction, into DNS
// wire form (length-prefixed labels and a terminating zero byte).
// ----------------------------------------------------------------------------
// A plain character or a dot that closes an empty label is taken without
// stalling the input. A dot that closes a label of n characters is accepted,
// then the input stalls while the length byte and the n characters are sent,
// since the sequencer replays the label store through its single read port
// at one byte per cycle while the output is not stalled. The end marker adds
// the zero byte. Labels longer than LABEL_MAX are cut, with label_truncated
// set on the length byte and characters of that label. A result register
// sits on the output, so a stalled result does not stall the input while
// characters are being collected.
// ----------------------------------------------------------------------------
module dns_name_label_encoder
    import dnle_pkg::*;
#(
    parameter int LABEL_MAX = 62
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] name_byte,
    input  logic              name_end,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last_of_run,
    output logic              label_truncated
);

    localparam int CNT_W  = $clog2(LABEL_MAX + 1);
    localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    emit_t             emit;
    logic              emit_ready;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_trunc_reg;

    dnle_ctrl #(
        .LABEL_MAX (LABEL_MAX),
        .CNT_W     (CNT_W),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .name_byte  (name_byte),
        .name_end   (name_end),
        .emit_ready (emit_ready),
        .emit       (emit),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    dnle_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (LABEL_MAX),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign emit_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (emit.valid && emit_ready)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid && emit_ready)
        begin
            out_byte_reg  <= emit.data;
            out_last_reg  <= emit.last;
            out_trunc_reg <= emit.trunc;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign last_of_run     = out_last_reg;
    assign label_truncated = out_trunc_reg;

endmodule

// ----- verif/dns_name_label_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_tb
// Self-checking testbench for the DNS name label encoder. A queue of name
// characters feeds a valid/stall driver, and a monitor predicts the wire form
// of each accepted transaction. It then checks every emitted byte against the
// prediction: length byte, label characters and terminating zero. The run
// covers empty, truncated and maximum-length labels under random idling on
// both sides.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_tb;
    import dnle_pkg::*;

    localparam int LABEL_MAX    = 62;
    localparam int RESET_CYCLES = 8;
    localparam int ITEM_TARGET  = 420;
    localparam int IDLE_PCT     = 9;
    localparam int QUIET_START  = 300;
    localparam int QUIET_END    = 700;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = LABEL_MAX + 16;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              fin;
        bit                hold;
    } name_item_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              trunc;
    } wire_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] name_byte = '0;
    logic              name_end = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              label_truncated;

    name_item_t        pending_items[$];
    wire_byte_t        wire_bytes_q[$];

    logic [BYTE_W-1:0] label_buf [LABEL_MAX];
    int                label_len = 0;
    logic              label_cut = 1'b0;

    int                cycle_count = 0;
    int                presented_count = 0;
    int                taken_count = 0;
    int                error_count = 0;
    bit                hold_next = 1'b0;

    dns_name_label_encoder #(
        .LABEL_MAX(LABEL_MAX)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .name_byte(name_byte),
        .name_end(name_end),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .last_of_run(last_of_run),
        .label_truncated(label_truncated)
    );

    always #6 clk = ~clk;

    function automatic bit quiet_window();
        return cycle_count >= QUIET_START && cycle_count < QUIET_END;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
    endtask

    task automatic add_item(input logic [BYTE_W-1:0] ch, input logic fin);
        name_item_t it;
        it.ch = ch;
        it.fin = fin;
        it.hold = hold_next;
        hold_next = 1'b0;
        pending_items.push_back(it);
    endtask

    task automatic add_label(input int len);
        int i;
        logic [BYTE_W-1:0] c;
        for (i = 0; i < len; i++)
        begin
            do
                c = BYTE_W'($urandom_range(0, 255));
            while (c == DOT_CHAR);
            add_item(c, 1'b0);
        end
    endtask

    task automatic push_wire_byte(input logic [BYTE_W-1:0] data, input logic last,
                                  input logic trunc);
        wire_byte_t wb;
        wb.data = data;
        wb.last = last;
        wb.trunc = trunc;
        wire_bytes_q.push_back(wb);
    endtask

    task automatic emit_label(input logic mark_last);
        int i;
        if (label_len != 0)
        begin
            push_wire_byte(BYTE_W'(label_len), 1'b0, label_cut);
            for (i = 0; i < label_len; i++)
                push_wire_byte(label_buf[i], mark_last && (i == label_len - 1), label_cut);
        end
        label_len = 0;
        label_cut = 1'b0;
    endtask

    task automatic encode_name_item(input logic [BYTE_W-1:0] ch, input logic fin);
        if (fin)
        begin
            emit_label(1'b0);
            push_wire_byte(ZERO_BYTE, 1'b1, 1'b0);
        end
        else if (ch == DOT_CHAR)
        begin
            emit_label(1'b1);
        end
        else if (label_len < LABEL_MAX)
        begin
            label_buf[label_len] = ch;
            label_len++;
        end
        else
        begin
            label_cut = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dns_name_label_encoder_tb NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        name_item_t nxt;
        bit         ready;
        if (cycle_count > RESET_CYCLES + 2 && (!in_valid || taken_count == presented_count))
        begin
            ready = pending_items.size() != 0;
            if (ready && pending_items[0].hold && wire_bytes_q.size() != 0)
                ready = 1'b0;
            if (ready && !quiet_window() && $urandom_range(0, 99) < IDLE_PCT)
                ready = 1'b0;
            if (ready)
            begin
                nxt = pending_items.pop_front();
                in_valid <= 1'b1;
                name_byte <= nxt.ch;
                name_end <= nxt.fin;
                presented_count++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= !quiet_window() && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        wire_byte_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (wire_bytes_q.size() == 0)
                begin
                    flag_mismatch("unexpected out_byte", out_byte, 0);
                end
                else
                begin
                    want = wire_bytes_q.pop_front();
                    if (out_byte !== want.data)
                        flag_mismatch("out_byte", out_byte, want.data);
                    if (last_of_run !== want.last)
                        flag_mismatch("last_of_run", last_of_run, want.last);
                    if (label_truncated !== want.trunc)
                        flag_mismatch("label_truncated", label_truncated, want.trunc);
                end
            end
            if (in_valid && !in_stall)
            begin
                encode_name_item(name_byte, name_end);
                taken_count++;
            end
        end
    end

    initial
    begin
        int r;
        int i;
        int nlabels;
        int len;
        bit mid_hold_done;

        mid_hold_done = 1'b0;

        add_item(DOT_CHAR, 1'b0);
        add_item(8'hFF, 1'b1);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(DOT_CHAR, 1'b0);
        add_item(DOT_CHAR, 1'b0);
        add_item(8'h61, 1'b0);
        add_item(8'h2D, 1'b0);
        add_item(8'h2F, 1'b0);
        add_item(DOT_CHAR, 1'b1);
        add_item(8'h7A, 1'b0);
        add_item(DOT_CHAR, 1'b0);
        add_item(DOT_CHAR, 1'b0);
        add_item(8'h00, 1'b1);
        add_item(8'h80, 1'b0);
        add_item(8'h01, 1'b0);
        add_item(8'h55, 1'b1);
        add_item(8'h00, 1'b1);
        add_item(DOT_CHAR, 1'b1);

        hold_next = 1'b1;
        add_label(LABEL_MAX);
        add_item(DOT_CHAR, 1'b0);
        add_label($urandom_range(LABEL_MAX + 1, LABEL_MAX + 8));
        add_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
        hold_next = 1'b1;

        while (pending_items.size() < ITEM_TARGET)
        begin
            if (!mid_hold_done && pending_items.size() > ITEM_TARGET / 2)
            begin
                hold_next = 1'b1;
                mid_hold_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_item(DOT_CHAR, 1'b0);
                nlabels = $urandom_range(1, 4);
                for (i = 0; i < nlabels; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        len = $urandom_range(LABEL_MAX - 4, LABEL_MAX + 6);
                    else if (r < 10)
                        len = 0;
                    else
                        len = $urandom_range(1, 12);
                    add_label(len);
                    if (i != nlabels - 1 || $urandom_range(0, 4) == 0)
                        add_item(DOT_CHAR, 1'b0);
                end
                add_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
            end
            else if (r < 90)
            begin
                len = $urandom_range(1, 15);
                for (i = 0; i < len; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 25)
                        add_item(DOT_CHAR, 1'b0);
                    else if (r < 30)
                        add_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
                    else
                        add_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
                end
            end
            else
            begin
                add_label($urandom_range(0, 6));
                add_item(DOT_CHAR, 1'b1);
                if ($urandom_range(0, 1) == 1)
                    add_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || taken_count != presented_count)
            @(posedge clk);
        while (wire_bytes_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (wire_bytes_q.size() != 0)
            flag_mismatch("missing out_byte count", 0, wire_bytes_q.size());

        if (error_count == 0)
            $display("dns_name_label_encoder_tb OK");
        else
            $display("dns_name_label_encoder_tb NOT OK");
        $finish;
    end

endmodule
